@@ hw/rtl/nns_pkg.sv @@
// Shared types, constants and helper functions for the nearest-neighbor scaler.
// Depends on nothing; imported by nns_div and nearest_neighbor_scaler.
package nns_pkg;

   localparam int MAX_SRC_DIM = 128;
   localparam int MAX_DST_DIM = 1024;

   // Field and register widths.
   localparam int COORD_W   = 10;
   localparam int PIXEL_W   = 32;
   localparam int SRC_REG_W = 8;
   localparam int DST_REG_W = 11;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;

   // Source coordinate width and frame store address width.
   localparam int SRC_W  = $clog2(MAX_SRC_DIM);
   localparam int ADDR_W = 2 * SRC_W;
   localparam int DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;

   // Scaled coordinate products: col * src_size with col < dst_size, so the
   // product stays below MAX_DST_DIM * MAX_SRC_DIM.
   localparam int DST_W  = $clog2(MAX_DST_DIM);
   localparam int MUL_W  = COORD_W + SRC_REG_W;
   localparam int PROD_W = DST_W + SRC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_SRC_WIDTH  = 2'd0,
      CFG_SRC_HEIGHT = 2'd1,
      CFG_DST_WIDTH  = 2'd2,
      CFG_DST_HEIGHT = 2'd3
   } cfg_index_type;

   // A size of zero acts as one; a size above the maximum acts as the maximum.
   function automatic logic [SRC_REG_W-1:0] clamp_src(input logic [SRC_REG_W-1:0] v);
      logic [SRC_REG_W-1:0] r;
      if (v == '0) begin
         r = SRC_REG_W'(1);
      end else if (v > SRC_REG_W'(MAX_SRC_DIM)) begin
         r = SRC_REG_W'(MAX_SRC_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [DST_REG_W-1:0] clamp_dst(input logic [DST_REG_W-1:0] v);
      logic [DST_REG_W-1:0] r;
      if (v == '0) begin
         r = DST_REG_W'(1);
      end else if (v > DST_REG_W'(MAX_DST_DIM)) begin
         r = DST_REG_W'(MAX_DST_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/nearest_neighbor_scaler.sv @@
// Nearest-neighbor image scaler: frame store, coordinate mapping and control.
// Depends on nns_pkg and instantiates the bit-serial divider nns_div.
//
// The block keeps a 128 x 128 source image of 32-bit RGBA pixels and answers
// requests for pixels of a scaled copy. A write request (func = 0) stores
// req_pixel_in at source column req_col and row req_row; it is absorbed in
// the cycle it is accepted, gives no response, and is dropped when the
// coordinate lies outside the configured source size. A read request
// (func = 1) names a destination coordinate; the block maps it to source
// column col * src_width / dst_width and source row row * src_height /
// dst_height (rounded down) and returns the stored pixel. A destination
// coordinate outside the configured destination size returns a zero pixel
// with rsp_out_of_range set; such a read goes straight to the done state and
// from there into the output register. An in-range read passes, per axis,
// through a multiply state and the shared divider, which retires one quotient
// bit per step, then takes the quotient; a registered frame store read and
// the load of the output register follow. A new request is taken only once
// the response is loaded, so reads never overlap; a read whose response finds
// the output register still full waits until it drains. Requests are handled
// one at a time; a new request is taken while a finished response still waits
// in the output register. Size registers must be written only while the block
// is idle; the block itself does not enforce this. A size of zero acts as one
// and a size above the maximum acts as the maximum. The frame store has no
// reset; reading a pixel that was never written returns an unspecified value.
module nearest_neighbor_scaler
   import nns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [PIXEL_W-1:0]   req_pixel_in,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIXEL_W-1:0]   rsp_pixel_out,
   output logic                 rsp_out_of_range,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Sequencer: for an in-range read, multiply and divide the column, then the
   // row, then read the frame store; every read ends in the output register.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_DIV_X,
      ST_MUL_Y,
      ST_DIV_Y,
      ST_READ,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Size registers as written, and their clamped working values.
   logic [SRC_REG_W-1:0] src_width_ff, src_width_in;
   logic [SRC_REG_W-1:0] src_height_ff, src_height_in;
   logic [DST_REG_W-1:0] dst_width_ff, dst_width_in;
   logic [DST_REG_W-1:0] dst_height_ff, dst_height_in;
   logic [SRC_REG_W-1:0] sw, sh;
   logic [DST_REG_W-1:0] dw, dh;

   // Request held while the mapping is worked out.
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic                 oor_ff, oor_in;
   logic [SRC_W-1:0]     sx_ff, sx_in;
   logic [SRC_W-1:0]     sy_ff, sy_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   // Frame store and its registered read port.
   logic [PIXEL_W-1:0]   frame_store_ff [DEPTH];
   logic [PIXEL_W-1:0]   rd_data_ff;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ADDR_W-1:0]    rd_addr;

   // Shared multiplier feeding the divider.
   logic [COORD_W-1:0]   mul_a;
   logic [SRC_REG_W-1:0] mul_b;
   logic [MUL_W-1:0]     mul_full;
   logic                 div_start;
   logic [DST_REG_W-1:0] div_divisor;
   logic                 div_done;
   logic [SRC_W-1:0]     div_quot;

   logic                 req_fire;
   logic                 req_in_dst;
   logic                 req_in_src;
   logic                 rsp_load;

   assign sw = clamp_src(src_width_ff);
   assign sh = clamp_src(src_height_ff);
   assign dw = clamp_dst(dst_width_ff);
   assign dh = clamp_dst(dst_height_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Range checks on the incoming coordinate, against destination for reads
   // and source for writes.
   assign req_in_dst = (DST_REG_W'(req_col) < dw) && (DST_REG_W'(req_row) < dh);
   assign req_in_src = (req_col < COORD_W'(sw)) && (req_row < COORD_W'(sh));

   assign wr_en   = req_fire && !req_func && req_in_src;
   assign wr_addr = {req_row[SRC_W-1:0], req_col[SRC_W-1:0]};
   assign rd_addr = {sy_ff, sx_ff};

   // The column product is scaled by the source width, the row product by
   // the source height; both are below MAX_DST_DIM * MAX_SRC_DIM because the
   // coordinate is already known to be in range.
   assign mul_a       = (state_ff == ST_MUL_Y) ? row_ff : col_ff;
   assign mul_b       = (state_ff == ST_MUL_Y) ? sh : sw;
   assign mul_full    = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign div_start   = (state_ff == ST_MUL_X) || (state_ff == ST_MUL_Y);
   assign div_divisor = (state_ff == ST_MUL_Y) ? dh : dw;

   nns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_full[PROD_W-1:0]),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // The output register takes a new response when it is empty or its
   // current one leaves in the same cycle.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      oor_in        = oor_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_oor_in    = rsp_oor_ff;

      if (csr_we) begin
         unique case (cfg_index_type'(csr_index))
            CFG_SRC_WIDTH:  src_width_in  = csr_wdata[SRC_REG_W-1:0];
            CFG_SRC_HEIGHT: src_height_in = csr_wdata[SRC_REG_W-1:0];
            CFG_DST_WIDTH:  dst_width_in  = csr_wdata[DST_REG_W-1:0];
            CFG_DST_HEIGHT: dst_height_in = csr_wdata[DST_REG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_func) begin
               col_in = req_col;
               row_in = req_row;
               oor_in = !req_in_dst;
               state_in = req_in_dst ? ST_MUL_X : ST_DONE;
            end
         end
         ST_MUL_X: state_in = ST_DIV_X;
         ST_DIV_X: begin
            if (div_done) begin
               sx_in    = div_quot;
               state_in = ST_MUL_Y;
            end
         end
         ST_MUL_Y: state_in = ST_DIV_Y;
         ST_DIV_Y: begin
            if (div_done) begin
               sy_in    = div_quot;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = oor_ff ? '0 : rd_data_ff;
               rsp_oor_in   = oor_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      oor_ff       <= oor_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_oor_ff   <= rsp_oor_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         src_width_ff  <= SRC_REG_W'(128);
         src_height_ff <= SRC_REG_W'(128);
         dst_width_ff  <= DST_REG_W'(128);
         dst_height_ff <= DST_REG_W'(128);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
      end
   end

   // Frame store: one write port driven by accepted in-range write requests, one
   // registered read port used once per in-range read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store_ff[wr_addr] <= req_pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // A response only appears after the sequencer finished a read.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_X || state_ff == ST_DIV_Y))
      else $error("divider finished while not awaited");

   // The mapped source coordinate always falls inside the source image.
   a_map_in_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (SRC_REG_W'(sx_ff) < sw && SRC_REG_W'(sy_ff) < sh))
      else $error("mapped coordinate outside the source image");

   // An out-of-range response never carries pixel data.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_pixel_ff == '0))
      else $error("out-of-range response with nonzero pixel");

endmodule

@@ hw/rtl/nns_div.sv @@
// Bit-serial restoring divider that produces one quotient bit per cycle.
// Depends on nns_pkg for the operand widths.
module nns_div
   import nns_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_W-1:0]    dividend,
   input  logic [DST_REG_W-1:0] divisor,
   output logic                 done,
   output logic [SRC_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(SRC_W + 1);

   // The quotient is known to be below MAX_SRC_DIM, so the upper dividend
   // bits already form a partial remainder smaller than the divisor.
   logic [DST_REG_W-1:0] rem_ff, rem_in;
   logic [DST_REG_W-1:0] div_ff, div_in;
   logic [SRC_W-1:0]     dq_ff, dq_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [DST_REG_W-1:0] trial;
   logic                 fits;

   assign trial = {rem_ff[DST_REG_W-2:0], dq_ff[SRC_W-1]};
   assign fits  = (trial >= div_ff);

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      dq_in   = dq_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = DST_REG_W'(dividend[PROD_W-1:SRC_W]);
         dq_in  = dividend[SRC_W-1:0];
         div_in = divisor;
         cnt_in = CNT_W'(SRC_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? (trial - div_ff) : trial;
         dq_in   = {dq_ff[SRC_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      dq_ff  <= dq_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule
